// File: design/jtu_pkg.sv
// ----------------------------------------------------------------------------
// jtu_pkg: shared types and constants for the JSON text unescape block
// Decode modes, entity characters, UTF-8 constants and the bundle of results
// that one input word produces.
// ----------------------------------------------------------------------------
`default_nettype none

package jtu_pkg;

    // Most results that one input word can produce
    localparam int MaxRes   = 4;
    localparam int CntWidth = $clog2(MaxRes + 1);

    // Characters seen in the raw text
    localparam logic [7:0] ChNul    = 8'h00;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChAmp    = 8'h26;
    localparam logic [7:0] ChApos   = 8'h27;
    localparam logic [7:0] ChSlash  = 8'h2f;
    localparam logic [7:0] ChSemi   = 8'h3b;
    localparam logic [7:0] ChGt     = 8'h3e;
    localparam logic [7:0] ChLt     = 8'h3c;
    localparam logic [7:0] ChBslash = 8'h5c;
    localparam logic [7:0] ChA      = 8'h61;
    localparam logic [7:0] ChG      = 8'h67;
    localparam logic [7:0] ChL      = 8'h6c;
    localparam logic [7:0] ChM      = 8'h6d;
    localparam logic [7:0] ChP      = 8'h70;
    localparam logic [7:0] ChT      = 8'h74;
    localparam logic [7:0] ChU      = 8'h75;

    // UTF-8 encoding constants
    localparam logic [15:0] Utf8OneLimit = 16'h0080;
    localparam logic [15:0] Utf8TwoLimit = 16'h0800;
    localparam logic [7:0]  Utf8Lead2    = 8'hc0;
    localparam logic [7:0]  Utf8Lead3    = 8'he0;
    localparam logic [7:0]  Utf8Cont     = 8'h80;
    localparam logic [5:0]  Utf8ContMask = 6'h3f;

    // Hex positions in a \u escape
    localparam logic [2:0] HexDigits = 3'd4;

    // Decode mode, one-hot
    typedef enum logic [12:0] {
        M_NORMAL  = 13'b0000000000001,
        M_AMP     = 13'b0000000000010,
        M_AMP_A   = 13'b0000000000100,
        M_AMP_AM  = 13'b0000000001000,
        M_AMP_AMP = 13'b0000000010000,
        M_AMP_G   = 13'b0000000100000,
        M_AMP_GT  = 13'b0000001000000,
        M_AMP_L   = 13'b0000010000000,
        M_AMP_LT  = 13'b0000100000000,
        M_ESC     = 13'b0001000000000,
        M_HEX     = 13'b0010000000000,
        M_ENDED   = 13'b0100000000000,
        M_PEND    = 13'b1000000000000
    } t_mode;

    // Results of one input word
    typedef struct packed {
        logic [MaxRes-1:0][7:0] bytes;
        logic [MaxRes-1:0]      has;
        logic [CntWidth-1:0]    cnt;
        logic                   text_end;
    } t_res_bundle;

    // Bytes held by a partly matched entity
    typedef struct packed {
        logic [MaxRes-1:0][7:0] bytes;
        logic [CntWidth-1:0]    cnt;
    } t_held;

    function automatic t_held held_of(input t_mode m);
        t_held h;
        h.bytes = '0;
        h.cnt   = '0;
        unique case (m)
            M_AMP:     begin h.bytes[0] = ChAmp; h.cnt = CntWidth'(1); end
            M_AMP_A:   begin
                h.bytes[0] = ChAmp; h.bytes[1] = ChA; h.cnt = CntWidth'(2);
            end
            M_AMP_AM:  begin
                h.bytes[0] = ChAmp; h.bytes[1] = ChA; h.bytes[2] = ChM;
                h.cnt = CntWidth'(3);
            end
            M_AMP_AMP: begin
                h.bytes[0] = ChAmp; h.bytes[1] = ChA; h.bytes[2] = ChM;
                h.bytes[3] = ChP; h.cnt = CntWidth'(4);
            end
            M_AMP_G:   begin
                h.bytes[0] = ChAmp; h.bytes[1] = ChG; h.cnt = CntWidth'(2);
            end
            M_AMP_GT:  begin
                h.bytes[0] = ChAmp; h.bytes[1] = ChG; h.bytes[2] = ChT;
                h.cnt = CntWidth'(3);
            end
            M_AMP_L:   begin
                h.bytes[0] = ChAmp; h.bytes[1] = ChL; h.cnt = CntWidth'(2);
            end
            M_AMP_LT:  begin
                h.bytes[0] = ChAmp; h.bytes[1] = ChL; h.bytes[2] = ChT;
                h.cnt = CntWidth'(3);
            end
            default:   h.cnt = '0;
        endcase
        return h;
    endfunction

endpackage

`default_nettype wire

// File: design/json_text_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_text_unescape_utf8: JSON string body decoder with UTF-8 output
// Decodes raw string bytes (entities, backslash escapes, \u hex) into bytes.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready  | i_text_byte, i_start_req
//   out     | output    | o_out_valid / i_out_ready| o_out_byte, o_has_byte,
//           |           |                          | o_text_end, o_last
//
// An input word is registered, decoded and its 0 to 4 results moved into the
// result register; an input word is taken every cycle while each word yields
// at most one result and i_out_ready is high. A word's results wait in the
// decode stage until the result register has room; it drains one result a
// cycle with i_out_ready. A word with no results passes without touching the
// output side. Reset is synchronous and clears the decode state and both valid
// flags. Output stalls back up into the input register and then into o_in_ready.
`default_nettype none

module json_text_unescape_utf8 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_start_req,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_has_byte,
    output logic             o_text_end,
    output logic             o_last
);
    import jtu_pkg::*;

    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;
    logic        s_commit;
    logic        s_load;
    logic        s_can_load;
    t_res_bundle s_res;

    // Commit the registered word once its results have room
    assign s_commit   = r_in_valid && ((s_res.cnt == '0) || s_can_load);
    assign s_load     = s_commit && (s_res.cnt != '0);
    assign o_in_ready = !r_in_valid || s_commit;

    always_comb begin
        n_in_valid = r_in_valid;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Hold the input word
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_text_byte;
            r_in_start <= i_start_req;
        end
    end

    jtu_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (s_commit),
        .i_text_byte (r_in_byte),
        .i_start_req (r_in_start),
        .o_res       (s_res)
    );

    jtu_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s_load),
        .i_res       (s_res),
        .o_can_load  (s_can_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_has_byte  (o_has_byte),
        .o_text_end  (o_text_end),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// File: design/jtu_decoder.sv
// ----------------------------------------------------------------------------
// jtu_decoder: decode state and per-word decode logic
// Holds the decode mode and \u accumulator, and works out from the current
// word all of its results and the next state. State advances on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module jtu_decoder (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_commit,
    input  wire logic [7:0]           i_text_byte,
    input  wire logic                 i_start_req,
    output jtu_pkg::t_res_bundle      o_res
);
    import jtu_pkg::*;

    t_mode       r_mode,      n_mode;
    logic [15:0] r_hex_value, n_hex_value;
    logic [2:0]  r_hex_digits, n_hex_digits;
    logic        r_hex_halted, n_hex_halted;

    t_res_bundle s_res;

    // Decode one word
    always_comb begin
        t_mode       s_mode;
        logic [15:0] s_hv;
        logic [2:0]  s_hd;
        logic        s_hh;
        logic        go_normal;
        logic        fin;
        logic        ent_lit_ok;
        logic [7:0]  ent_lit;
        logic        ent_next_ok;
        t_mode       ent_next;
        t_held       held;
        logic        dig_ok;
        logic [3:0]  dig;
        logic [15:0] hv;
        logic [2:0]  hd;
        logic [7:0]  b;

        b           = i_text_byte;
        s_mode      = r_mode;
        s_hv        = r_hex_value;
        s_hd        = r_hex_digits;
        s_hh        = r_hex_halted;
        // Restart before this word
        if (i_start_req) begin
            s_mode = M_NORMAL;
            s_hv   = '0;
            s_hd   = '0;
            s_hh   = 1'b0;
        end

        s_res        = '0;
        go_normal    = 1'b0;
        fin          = 1'b0;
        ent_lit_ok   = 1'b0;
        ent_lit      = '0;
        ent_next_ok  = 1'b0;
        ent_next     = M_NORMAL;
        held         = held_of(s_mode);
        dig_ok       = 1'b0;
        dig          = '0;
        hv           = s_hv;
        hd           = s_hd;

        // Flush a deferred literal first
        if (s_mode == M_PEND) begin
            s_res.bytes[0] = s_hv[7:0];
            s_res.has[0]   = 1'b1;
            s_res.cnt      = CntWidth'(1);
            s_hv           = '0;
            s_mode         = M_NORMAL;
        end

        n_mode       = s_mode;
        n_hex_value  = s_hv;
        n_hex_digits = s_hd;
        n_hex_halted = s_hh;

        // Entity matching
        unique case (s_mode)
            M_AMP: begin
                if (b == ChA) begin
                    ent_next_ok = 1'b1; ent_next = M_AMP_A;
                end else if (b == ChG) begin
                    ent_next_ok = 1'b1; ent_next = M_AMP_G;
                end else if (b == ChL) begin
                    ent_next_ok = 1'b1; ent_next = M_AMP_L;
                end
            end
            M_AMP_A:   begin ent_next_ok = (b == ChM); ent_next = M_AMP_AM;  end
            M_AMP_AM:  begin ent_next_ok = (b == ChP); ent_next = M_AMP_AMP; end
            M_AMP_AMP: begin ent_lit_ok  = (b == ChSemi); ent_lit = ChAmp;   end
            M_AMP_G:   begin ent_next_ok = (b == ChT); ent_next = M_AMP_GT;  end
            M_AMP_GT:  begin ent_lit_ok  = (b == ChSemi); ent_lit = ChGt;    end
            M_AMP_L:   begin ent_next_ok = (b == ChT); ent_next = M_AMP_LT;  end
            M_AMP_LT:  begin ent_lit_ok  = (b == ChSemi); ent_lit = ChLt;    end
            default:   ent_lit_ok = 1'b0;
        endcase

        // Hex digit value
        if (b >= 8'h30 && b <= 8'h39) begin
            dig_ok = 1'b1; dig = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            dig_ok = 1'b1; dig = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            dig_ok = 1'b1; dig = 4'(b - 8'h37);
        end

        unique case (s_mode)
            M_ENDED: n_mode = M_ENDED;
            M_AMP, M_AMP_A, M_AMP_AM, M_AMP_AMP, M_AMP_G, M_AMP_GT, M_AMP_L,
            M_AMP_LT: begin
                if (ent_lit_ok) begin
                    s_res.bytes[0] = ent_lit;
                    s_res.has[0]   = 1'b1;
                    s_res.cnt      = CntWidth'(1);
                    n_mode         = M_NORMAL;
                end else if (ent_next_ok) begin
                    n_mode = ent_next;
                end else begin
                    // Emit the held bytes, then treat this word as plain text
                    s_res.bytes = held.bytes;
                    for (int i = 0; i < MaxRes; i++) begin
                        s_res.has[i] = (CntWidth'(i) < held.cnt);
                    end
                    s_res.cnt = held.cnt;
                    go_normal = 1'b1;
                end
            end
            M_ESC: begin
                if (b == ChNul) begin
                    fin = 1'b1;
                end else if (b == ChU) begin
                    n_hex_value  = '0;
                    n_hex_digits = '0;
                    n_hex_halted = 1'b0;
                    n_mode       = M_HEX;
                end else if (b == ChApos || b == ChQuote || b == ChSlash) begin
                    s_res.bytes[0] = b;
                    s_res.has[0]   = 1'b1;
                    s_res.cnt      = CntWidth'(1);
                    n_mode         = M_NORMAL;
                end else begin
                    s_res.bytes[0] = ChBslash;
                    s_res.bytes[1] = b;
                    s_res.has[1:0] = 2'b11;
                    s_res.cnt      = CntWidth'(2);
                    n_mode         = M_NORMAL;
                end
            end
            M_HEX: begin
                if (b == ChNul) begin
                    fin = 1'b1;
                end else begin
                    // Accumulate until the first non-hex byte
                    if (!s_hh && dig_ok) begin
                        hv = {s_hv[11:0], dig};
                    end else begin
                        n_hex_halted = 1'b1;
                    end
                    hd           = s_hd + 3'd1;
                    n_hex_value  = hv;
                    n_hex_digits = hd;
                    if (hd >= HexDigits) begin
                        if (hv < Utf8OneLimit) begin
                            s_res.bytes[0] = hv[7:0];
                            s_res.has[0]   = 1'b1;
                            s_res.cnt      = CntWidth'(1);
                        end else if (hv < Utf8TwoLimit) begin
                            s_res.bytes[0] = Utf8Lead2 + {3'b000, hv[10:6]};
                            s_res.bytes[1] = Utf8Cont + {2'b00, hv[5:0] & Utf8ContMask};
                            s_res.has[1:0] = 2'b11;
                            s_res.cnt      = CntWidth'(2);
                        end else begin
                            s_res.bytes[0] = Utf8Lead3 + {4'b0000, hv[15:12]};
                            s_res.bytes[1] = Utf8Cont + {2'b00, hv[11:6] & Utf8ContMask};
                            s_res.bytes[2] = Utf8Cont + {2'b00, hv[5:0] & Utf8ContMask};
                            s_res.has[2:0] = 3'b111;
                            s_res.cnt      = CntWidth'(3);
                        end
                        n_hex_value  = '0;
                        n_hex_digits = '0;
                        n_hex_halted = 1'b0;
                        n_mode       = M_NORMAL;
                    end
                end
            end
            default: go_normal = 1'b1;
        endcase

        // Plain text handling
        if (go_normal) begin
            n_mode = M_NORMAL;
            if (b == ChNul || b == ChQuote) begin
                fin = 1'b1;
            end else if (b == ChAmp) begin
                n_mode = M_AMP;
            end else if (b == ChBslash) begin
                n_mode = M_ESC;
            end else if (s_res.cnt < CntWidth'(MaxRes)) begin
                s_res.bytes[s_res.cnt[1:0]] = b;
                s_res.has[s_res.cnt[1:0]]   = 1'b1;
                s_res.cnt                   = s_res.cnt + CntWidth'(1);
            end else begin
                // No room left: defer the literal to the next word
                n_hex_value = {8'h00, b};
                n_mode      = M_PEND;
            end
        end

        // End of text
        if (fin) begin
            if (s_res.cnt == '0) begin
                s_res.bytes[0] = '0;
                s_res.has[0]   = 1'b0;
                s_res.cnt      = CntWidth'(1);
            end
            s_res.text_end = 1'b1;
            n_mode         = M_ENDED;
        end
    end

    assign o_res = s_res;

    // Advance state on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_NORMAL;
            r_hex_value  <= '0;
            r_hex_digits <= '0;
            r_hex_halted <= 1'b0;
        end else if (i_commit) begin
            r_mode       <= n_mode;
            r_hex_value  <= n_hex_value;
            r_hex_digits <= n_hex_digits;
            r_hex_halted <= n_hex_halted;
        end
    end

endmodule

`default_nettype wire

// File: design/jtu_out_buf.sv
// ----------------------------------------------------------------------------
// jtu_out_buf: result register and serializer
// Holds the results of one input word and hands them out one result a cycle
// while i_out_ready is high, marking the final one and the end of text.
// ----------------------------------------------------------------------------
`default_nettype none

module jtu_out_buf (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  jtu_pkg::t_res_bundle      i_res,
    output logic                      o_can_load,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [7:0]                o_out_byte,
    output logic                      o_has_byte,
    output logic                      o_text_end,
    output logic                      o_last
);
    import jtu_pkg::*;

    localparam int IdxWidth = $clog2(MaxRes);

    logic [MaxRes-1:0][7:0]       r_bytes;
    logic [MaxRes-1:0]            r_has;
    logic                         r_end;
    logic [CntWidth-1:0]          r_rem,  n_rem;
    logic [IdxWidth-1:0]          r_idx,  n_idx;
    logic                         s_last;
    logic                         s_take;

    assign s_last      = (r_rem == CntWidth'(1));
    assign s_take      = o_out_valid && i_out_ready;
    assign o_out_valid = (r_rem != '0);
    assign o_can_load  = (r_rem == '0) || (s_last && i_out_ready);
    assign o_out_byte  = r_bytes[r_idx];
    assign o_has_byte  = r_has[r_idx];
    assign o_last      = s_last;
    assign o_text_end  = r_end && s_last;

    // Count down the held results
    always_comb begin
        n_rem = r_rem;
        n_idx = r_idx;
        if (i_load) begin
            n_rem = i_res.cnt;
            n_idx = '0;
        end else if (s_take) begin
            n_rem = r_rem - CntWidth'(1);
            n_idx = r_idx + IdxWidth'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_idx <= '0;
        end else begin
            r_rem <= n_rem;
            r_idx <= n_idx;
        end
    end

    // Capture payload on load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_res.bytes;
            r_has   <= i_res.has;
            r_end   <= i_res.text_end;
        end
    end

endmodule

`default_nettype wire
